// ----- hdl/assert_macros.svh -----
// assertion macros shared by the projection pipeline modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/ppts_pkg.sv -----
// shared types and constants of the perspective projection pipeline
`timescale 1ns / 1ps

package ppts_pkg;

  localparam int COORD_W   = 32;
  localparam int NUM_W     = 63;
  localparam int MAG_W     = 49;
  localparam int SPAN_W    = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [MAG_W-1:0] MAG_LIMIT = 49'h1_0000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_DIST = 2'd0,
    REG_ASPECT    = 2'd1,
    REG_VP_WIDTH  = 2'd2,
    REG_VP_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic               skip;
    logic               zdepth;
    logic               xneg;
    logic               yneg;
    logic               nx_nz;
    logic               ny_nz;
    logic               last;
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0]   wx;
    logic [NUM_W-1:0]   wy;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
    logic [COORD_W-1:0] zm;
    side_t              side;
  } div_stage_t;

  typedef struct packed {
    logic [COORD_W-1:0] screen_x;
    logic [COORD_W-1:0] screen_y;
    logic               skipped;
    logic               zero_depth;
    logic               saturated;
    logic               last;
  } result_t;

endpackage

// ----- hdl/ppts_front.sv -----
// input register, magnitude/sign split and view distance multiply
`timescale 1ns / 1ps

module ppts_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic [ppts_pkg::COORD_W-1:0]   view_distance,
  input  logic signed [ppts_pkg::COORD_W-1:0] cam_x,
  input  logic signed [ppts_pkg::COORD_W-1:0] cam_y,
  input  logic signed [ppts_pkg::COORD_W-1:0] cam_z,
  input  logic                           poly_active,
  input  logic                           poly_clipped,
  input  logic                           poly_backface,
  input  logic                           last_in_list,
  output logic                           out_vld,
  output ppts_pkg::div_stage_t           out_stage
);

  localparam int W   = ppts_pkg::COORD_W;
  localparam int MSB = ppts_pkg::COORD_W - 1;

  logic         v0, v1, v2;
  logic [W-1:0] x0, y0, z0;
  logic         act0, clip0, back0, last0;

  ppts_pkg::side_t side1, side_next;
  logic [W-1:0]    magx1, magy1, zm1;
  logic [W-1:0]    magx_next, magy_next, zm_next;

  ppts_pkg::div_stage_t stage2, stage_next;
  logic [2*W-1:0]       prod_x, prod_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= in_vld;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0     <= cam_x;
      y0     <= cam_y;
      z0     <= cam_z;
      act0   <= poly_active;
      clip0  <= poly_clipped;
      back0  <= poly_backface;
      last0  <= last_in_list;
      side1  <= side_next;
      magx1  <= magx_next;
      magy1  <= magy_next;
      zm1    <= zm_next;
      stage2 <= stage_next;
    end
  end

  // magnitudes and result signs
  always_comb begin
    side_next        = '0;
    side_next.skip   = !act0 || clip0 || back0;
    side_next.zdepth = (z0 == '0);
    side_next.xneg   = x0[MSB] ^ z0[MSB];
    side_next.yneg   = y0[MSB] ^ z0[MSB];
    side_next.last   = last0;
    side_next.raw_x  = x0;
    side_next.raw_y  = y0;
    magx_next        = x0[MSB] ? (~x0 + 1'b1) : x0;
    magy_next        = y0[MSB] ? (~y0 + 1'b1) : y0;
    zm_next          = z0[MSB] ? (~z0 + 1'b1) : z0;
  end

  // numerators d*|x| and d*|y|
  always_comb begin
    prod_x           = {{W{1'b0}}, view_distance} * {{W{1'b0}}, magx1};
    prod_y           = {{W{1'b0}}, view_distance} * {{W{1'b0}}, magy1};
    stage_next       = '0;
    stage_next.wx    = prod_x[ppts_pkg::NUM_W-1:0];
    stage_next.wy    = prod_y[ppts_pkg::NUM_W-1:0];
    stage_next.zm    = zm1;
    stage_next.side  = side1;
    stage_next.side.nx_nz = (view_distance != '0) && (magx1 != '0);
    stage_next.side.ny_nz = (view_distance != '0) && (magy1 != '0);
  end

  assign out_vld   = v2;
  assign out_stage = stage2;

endmodule

// ----- hdl/ppts_div.sv -----
// pipelined restoring divider, one quotient bit per stage for x and y
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppts_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  ppts_pkg::div_stage_t in_stage,
  output logic                 out_vld,
  output ppts_pkg::div_stage_t out_stage
);

  localparam int N    = ppts_pkg::NUM_W;
  localparam int W    = ppts_pkg::COORD_W;
  localparam int LAST = N - 1;

  ppts_pkg::div_stage_t st      [N];
  ppts_pkg::div_stage_t st_in   [N];
  ppts_pkg::div_stage_t st_next [N];
  logic [N-1:0]         vld;
  ppts_pkg::div_stage_t fin;

  // shift the next numerator bit in, subtract when it fits
  function automatic ppts_pkg::div_stage_t div_step(input ppts_pkg::div_stage_t s);
    logic [W:0]           rem_x;
    logic [W:0]           rem_y;
    logic                 ge_x;
    logic                 ge_y;
    ppts_pkg::div_stage_t r;
    rem_x = {s.rx, s.wx[N-1]};
    rem_y = {s.ry, s.wy[N-1]};
    ge_x  = rem_x >= {1'b0, s.zm};
    ge_y  = rem_y >= {1'b0, s.zm};
    r     = s;
    r.wx  = {s.wx[N-2:0], ge_x};
    r.wy  = {s.wy[N-2:0], ge_y};
    r.rx  = ge_x ? W'(rem_x - {1'b0, s.zm}) : rem_x[W-1:0];
    r.ry  = ge_y ? W'(rem_y - {1'b0, s.zm}) : rem_y[W-1:0];
    return r;
  endfunction

  for (genvar i = 0; i < N; i++) begin : g_stage
    if (i == 0) begin : g_head
      assign st_in[i] = in_stage;
    end else begin : g_body
      assign st_in[i] = st[i-1];
    end
    assign st_next[i] = div_step(st_in[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        st[k] <= st_next[k];
      end
    end
  end

  assign fin       = st[LAST];
  assign out_vld   = vld[LAST];
  assign out_stage = fin;

  `ASSERT_IMPLY(a_rem_lt_div, clk, rst, vld[LAST] && fin.zm != '0, fin.rx < fin.zm && fin.ry < fin.zm)

endmodule

// ----- hdl/ppts_back.sv -----
// aspect scaling, clamping, viewport mapping and saturation
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppts_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_vld,
  input  ppts_pkg::div_stage_t           in_stage,
  input  logic [ppts_pkg::COORD_W-1:0]   aspect_ratio,
  input  logic [ppts_pkg::SPAN_W-1:0]    viewport_width,
  input  logic [ppts_pkg::SPAN_W-1:0]    viewport_height,
  output logic                           out_vld,
  output ppts_pkg::result_t              out_res
);

  localparam int W          = ppts_pkg::COORD_W;
  localparam int N          = ppts_pkg::NUM_W;
  localparam int MW         = ppts_pkg::MAG_W;
  localparam int SW         = ppts_pkg::SPAN_W;
  localparam int HI_W       = 2 * W - 1;
  localparam int LO_W       = 2 * W - FRAC_BITS;
  localparam int HI_SHIFT   = W - FRAC_BITS;
  localparam int HI_LIM_BIT = MW - 1 - HI_SHIFT;
  localparam int A_W        = SW + FRAC_BITS - 1;
  localparam int PX_W       = MW + 1;
  localparam int PROD_W     = SW + 1 + PX_W;
  localparam int SUM_W      = PROD_W;

  localparam logic [HI_W-1:0]         HI_LIMIT = {{(HI_W-1){1'b0}}, 1'b1} << HI_LIM_BIT;
  localparam logic signed [SUM_W-1:0] SAT_MAX  = SUM_W'(32'h7fff_ffff);
  localparam logic signed [SUM_W-1:0] SAT_MIN  = ~SAT_MAX;
  localparam logic [W-1:0]            XMAX     = SAT_MAX[W-1:0];
  localparam logic [W-1:0]            XMIN     = SAT_MIN[W-1:0];

  logic v1, v2, v3, v4, v5, v6;

  ppts_pkg::side_t side1, side2, side3, side4, side5;

  logic [MW-1:0]   pxc1, pxc_next;
  logic [HI_W-1:0] hi1, hi_next;
  logic [LO_W-1:0] lo1, lo_next;
  logic [2*W-1:0]  hi_prod, lo_prod;

  logic [MW-1:0]   pxm2, pym2, pxm_next, pym_next, scaled;
  logic [2*W-1:0]  t_sum;

  logic signed [PX_W-1:0]   px3, py3, px_next, py_next;
  logic signed [PROD_W-1:0] prodx4, prody4, prodx_next, prody_next;
  logic signed [SUM_W-1:0]  sumx5, sumy5, sumx_next, sumy_next;

  logic [SW-1:0]  sw_r, sh_r;
  logic [A_W-1:0] a_r, b_r;

  ppts_pkg::result_t res6, res_next;
  logic              sat_x, sat_y;
  logic [W-1:0]      sx, sy;
  logic              at_rail;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // viewport spans and centers follow the size registers
  always_ff @(posedge clk) begin
    sw_r <= (viewport_width == '0) ? '0 : viewport_width - 1'b1;
    sh_r <= (viewport_height == '0) ? '0 : viewport_height - 1'b1;
    a_r  <= {sw_r, {(FRAC_BITS-1){1'b0}}};
    b_r  <= {sh_r, {(FRAC_BITS-1){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1  <= in_stage.side;
      pxc1   <= pxc_next;
      hi1    <= hi_next;
      lo1    <= lo_next;
      side2  <= side1;
      pxm2   <= pxm_next;
      pym2   <= pym_next;
      side3  <= side2;
      px3    <= px_next;
      py3    <= py_next;
      side4  <= side3;
      prodx4 <= prodx_next;
      prody4 <= prody_next;
      side5  <= side4;
      sumx5  <= sumx_next;
      sumy5  <= sumy_next;
      res6   <= res_next;
    end
  end

  // clamp qx, split qy * aspect into two partial products
  always_comb begin
    pxc_next = (in_stage.wx > N'(ppts_pkg::MAG_LIMIT)) ? ppts_pkg::MAG_LIMIT
                                                       : in_stage.wx[MW-1:0];
    hi_prod  = {{(W+1){1'b0}}, in_stage.wy[N-1:W]} * {{W{1'b0}}, aspect_ratio};
    lo_prod  = {{W{1'b0}}, in_stage.wy[W-1:0]} * {{W{1'b0}}, aspect_ratio};
    hi_next  = hi_prod[HI_W-1:0];
    lo_next  = lo_prod[2*W-1:FRAC_BITS];
  end

  // recombine, clamp, zero depth override
  always_comb begin
    t_sum  = ((2*W)'(hi1) << HI_SHIFT) + (2*W)'(lo1);
    scaled = (hi1 > HI_LIMIT || t_sum > (2*W)'(ppts_pkg::MAG_LIMIT)) ? ppts_pkg::MAG_LIMIT
                                                                     : t_sum[MW-1:0];
    if (side1.zdepth) begin
      pxm_next = side1.nx_nz ? ppts_pkg::MAG_LIMIT : '0;
      pym_next = (side1.ny_nz && aspect_ratio != '0) ? ppts_pkg::MAG_LIMIT : '0;
    end else begin
      pxm_next = pxc1;
      pym_next = scaled;
    end
  end

  always_comb begin
    px_next = side2.xneg ? -$signed({1'b0, pxm2}) : $signed({1'b0, pxm2});
    py_next = side2.yneg ? -$signed({1'b0, pym2}) : $signed({1'b0, pym2});
  end

  always_comb begin
    prodx_next = $signed({1'b0, sw_r}) * px3;
    prody_next = $signed({1'b0, sh_r}) * py3;
  end

  always_comb begin
    sumx_next = $signed(SUM_W'(a_r)) + (prodx4 >>> 1);
    sumy_next = $signed(SUM_W'(b_r)) - (prody4 >>> 1);
  end

  // saturate, pass skipped vertices through
  always_comb begin
    sat_x = 1'b0;
    sat_y = 1'b0;
    if (sumx5 > SAT_MAX) begin
      sx    = XMAX;
      sat_x = 1'b1;
    end else if (sumx5 < SAT_MIN) begin
      sx    = XMIN;
      sat_x = 1'b1;
    end else begin
      sx = sumx5[W-1:0];
    end
    if (sumy5 > SAT_MAX) begin
      sy    = XMAX;
      sat_y = 1'b1;
    end else if (sumy5 < SAT_MIN) begin
      sy    = XMIN;
      sat_y = 1'b1;
    end else begin
      sy = sumy5[W-1:0];
    end
    res_next.last    = side5.last;
    res_next.skipped = side5.skip;
    if (side5.skip) begin
      res_next.screen_x   = side5.raw_x;
      res_next.screen_y   = side5.raw_y;
      res_next.zero_depth = 1'b0;
      res_next.saturated  = 1'b0;
    end else begin
      res_next.screen_x   = sx;
      res_next.screen_y   = sy;
      res_next.zero_depth = side5.zdepth;
      res_next.saturated  = sat_x || sat_y;
    end
  end

  assign out_vld = v6;
  assign out_res = res6;

  assign at_rail = res6.screen_x == XMAX || res6.screen_x == XMIN ||
                   res6.screen_y == XMAX || res6.screen_y == XMIN;

  `ASSERT_IMPLY(a_sat_on_rail, clk, rst, v6 && res6.saturated, at_rail)
  `ASSERT_IMPLY(a_skip_clean, clk, rst, v6 && res6.skipped, !res6.zero_depth && !res6.saturated)

endmodule

// ----- hdl/ppts_outbuf.sv -----
// two-entry output buffer that decouples pipeline advance from the consumer
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppts_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  ppts_pkg::result_t in_res,
  output logic              take,
  input  logic              out_rdy,
  output logic              out_vld,
  output ppts_pkg::result_t out_res
);

  logic              head_valid, skid_valid;
  ppts_pkg::result_t head, skid;
  logic              push, pop;

  assign take = !skid_valid;
  assign push = in_vld && take;
  assign pop  = head_valid && out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        head_valid <= 1'b0;
      end
    end else if (push) begin
      if (head_valid) begin
        skid_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head <= skid;
      end else if (push) begin
        head <= in_res;
      end
    end else if (push) begin
      if (head_valid) begin
        skid <= in_res;
      end else begin
        head <= in_res;
      end
    end
  end

  assign out_vld = head_valid;
  assign out_res = head;

  `ASSERT_IMPLY(a_skid_needs_head, clk, rst, skid_valid, head_valid)
  `ASSERT_NEXT(a_skid_fills, clk, rst, push && head_valid && !pop, skid_valid && head_valid)

endmodule

// ----- hdl/perspective_project_to_screen_top.sv -----
// top level of the perspective divide and viewport mapping pipeline
`timescale 1ns / 1ps

// an accepted request passes 3 front stages, the 63-stage restoring divider (one
// quotient bit per stage), 6 back stages and the output buffer register before
// out_valid, the first of them loaded at the accepting edge
// throughput: one vertex per cycle; a 2-entry output buffer keeps input flowing
// while one result waits, and the pipeline stalls only when both entries are full
// reset: synchronous, clears all valid bits, distance and aspect 1.0, viewport 640 x 480

module perspective_project_to_screen_top #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ppts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ppts_pkg::COORD_W-1:0]          cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [ppts_pkg::COORD_W-1:0]   cam_x,
  input  logic signed [ppts_pkg::COORD_W-1:0]   cam_y,
  input  logic signed [ppts_pkg::COORD_W-1:0]   cam_z,
  input  logic                                  poly_active,
  input  logic                                  poly_clipped,
  input  logic                                  poly_backface,
  input  logic                                  last_in_list,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ppts_pkg::COORD_W-1:0]   screen_x,
  output logic signed [ppts_pkg::COORD_W-1:0]   screen_y,
  output logic                                  skipped,
  output logic                                  zero_depth,
  output logic                                  saturated,
  output logic                                  last_out
);

  localparam int W  = ppts_pkg::COORD_W;
  localparam int SW = ppts_pkg::SPAN_W;

  localparam logic [W-1:0]  ONE_FIX   = W'(1) << COORD_FRAC_BITS;
  localparam logic [SW-1:0] VP_W_INIT = 13'd640;
  localparam logic [SW-1:0] VP_H_INIT = 13'd480;

  logic [W-1:0]  view_distance, aspect_ratio;
  logic [SW-1:0] viewport_width, viewport_height;

  logic                 advance;
  logic                 front_vld, div_vld, back_vld;
  ppts_pkg::div_stage_t front_stage, div_stage;
  ppts_pkg::result_t    back_res, head_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_distance   <= ONE_FIX;
      aspect_ratio    <= ONE_FIX;
      viewport_width  <= VP_W_INIT;
      viewport_height <= VP_H_INIT;
    end else if (cfg_we) begin
      case (ppts_pkg::cfg_reg_t'(cfg_index))
        ppts_pkg::REG_VIEW_DIST: view_distance   <= cfg_data;
        ppts_pkg::REG_ASPECT:    aspect_ratio    <= cfg_data;
        ppts_pkg::REG_VP_WIDTH:  viewport_width  <= cfg_data[SW-1:0];
        ppts_pkg::REG_VP_HEIGHT: viewport_height <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = advance;

  ppts_front u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .in_vld        (in_valid),
    .view_distance (view_distance),
    .cam_x         (cam_x),
    .cam_y         (cam_y),
    .cam_z         (cam_z),
    .poly_active   (poly_active),
    .poly_clipped  (poly_clipped),
    .poly_backface (poly_backface),
    .last_in_list  (last_in_list),
    .out_vld       (front_vld),
    .out_stage     (front_stage)
  );

  ppts_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_vld    (front_vld),
    .in_stage  (front_stage),
    .out_vld   (div_vld),
    .out_stage (div_stage)
  );

  ppts_back #(
    .FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .en              (advance),
    .in_vld          (div_vld),
    .in_stage        (div_stage),
    .aspect_ratio    (aspect_ratio),
    .viewport_width  (viewport_width),
    .viewport_height (viewport_height),
    .out_vld         (back_vld),
    .out_res         (back_res)
  );

  ppts_outbuf u_outbuf (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (back_vld),
    .in_res  (back_res),
    .take    (advance),
    .out_rdy (out_ready),
    .out_vld (out_valid),
    .out_res (head_res)
  );

  assign screen_x   = head_res.screen_x;
  assign screen_y   = head_res.screen_y;
  assign skipped    = head_res.skipped;
  assign zero_depth = head_res.zero_depth;
  assign saturated  = head_res.saturated;
  assign last_out   = head_res.last;

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the perspective divide and viewport mapping pipeline
`timescale 1ns / 1ps

module tb;

  localparam int FRAC = 16;
  localparam longint unsigned MAG_CAP = 64'd1 << 48;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 80;
  localparam int BLOCK_ITEMS = 50;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        active;
    logic        clipped;
    logic        backface;
    logic        last;
  } cam_vertex_t;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        skipped;
    logic        zdepth;
    logic        sat;
    logic        last;
  } screen_vertex_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [ppts_pkg::CFG_IDX_W-1:0] cfg_index = ppts_pkg::REG_VIEW_DIST;
  logic [ppts_pkg::COORD_W-1:0]   cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [ppts_pkg::COORD_W-1:0]   cam_x = '0;
  logic [ppts_pkg::COORD_W-1:0]   cam_y = '0;
  logic [ppts_pkg::COORD_W-1:0]   cam_z = '0;
  logic                           poly_active = 1'b0;
  logic                           poly_clipped = 1'b0;
  logic                           poly_backface = 1'b0;
  logic                           last_in_list = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [ppts_pkg::COORD_W-1:0]   screen_x;
  logic [ppts_pkg::COORD_W-1:0]   screen_y;
  logic                           skipped;
  logic                           zero_depth;
  logic                           saturated;
  logic                           last_out;

  longint unsigned view_dist;
  longint unsigned aspect;
  int unsigned     vp_w;
  int unsigned     vp_h;

  screen_vertex_t  expected_screen[$];
  screen_vertex_t  want_screen;
  int              mismatch_count = 0;
  int              cycle_count = 0;
  int              send_idle_pct = 22;
  int              recv_idle_pct = 73;

  perspective_project_to_screen_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cam_x        (cam_x),
    .cam_y        (cam_y),
    .cam_z        (cam_z),
    .poly_active  (poly_active),
    .poly_clipped (poly_clipped),
    .poly_backface(poly_backface),
    .last_in_list (last_in_list),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .screen_x     (screen_x),
    .screen_y     (screen_y),
    .skipped      (skipped),
    .zero_depth   (zero_depth),
    .saturated    (saturated),
    .last_out     (last_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned mag_of(logic [31:0] v);
    longint s;
    s = $signed(v);
    if (s < 0) s = -s;
    return s;
  endfunction

  function automatic logic [32:0] clamp32(longint v);
    if (v > S32_MAX) return {1'b1, 32'h7fff_ffff};
    if (v < S32_MIN) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic screen_vertex_t project_vertex(cam_vertex_t v);
    screen_vertex_t  r;
    longint unsigned nx, ny, zm, pxm, pym;
    logic [95:0]     wide;
    logic            xneg, yneg;
    longint          px, py, sw, sh;
    logic [32:0]     cx, cy;
    r = '0;
    r.last = v.last;
    if (!v.active || v.clipped || v.backface) begin
      r.sx = v.x;
      r.sy = v.y;
      r.skipped = 1'b1;
      return r;
    end
    nx = view_dist * mag_of(v.x);
    ny = view_dist * mag_of(v.y);
    xneg = v.x[31];
    yneg = v.y[31];
    if (v.z == '0) begin
      r.zdepth = 1'b1;
      pxm = (nx != 0) ? MAG_CAP : 64'd0;
      pym = (ny != 0 && aspect != 0) ? MAG_CAP : 64'd0;
    end else begin
      zm = mag_of(v.z);
      if (v.z[31]) begin
        xneg = !xneg;
        yneg = !yneg;
      end
      pxm = nx / zm;
      if (pxm > MAG_CAP) pxm = MAG_CAP;
      wide = (96'(ny / zm) * 96'(aspect)) >> FRAC;
      pym = (wide > 96'(MAG_CAP)) ? MAG_CAP : wide[63:0];
    end
    px = xneg ? -longint'(pxm) : longint'(pxm);
    py = yneg ? -longint'(pym) : longint'(pym);
    // a zero viewport size acts as one pixel
    sw = (vp_w == 0) ? 0 : longint'(vp_w) - 1;
    sh = (vp_h == 0) ? 0 : longint'(vp_h) - 1;
    cx = clamp32(sw * (64'sd1 <<< (FRAC - 1)) + ((sw * px) >>> 1));
    cy = clamp32(sh * (64'sd1 <<< (FRAC - 1)) - ((sh * py) >>> 1));
    r.sx = cx[31:0];
    r.sy = cy[31:0];
    r.sat = cx[32] | cy[32];
    return r;
  endfunction

  function automatic cam_vertex_t make_vertex(logic [31:0] x, logic [31:0] y,
                                              logic [31:0] z, logic act,
                                              logic clip, logic back, logic last);
    cam_vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    v.active = act;
    v.clipped = clip;
    v.backface = back;
    v.last = last;
    return v;
  endfunction

  function automatic logic [31:0] pick_coord();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(7))
      0, 1: return r;
      2, 3: return {{11{r[20]}}, r[20:0]};
      4: return {{6{r[25]}}, r[25:0]};
      5: begin
        case ($urandom_range(4))
          0: return 32'h0;
          1: return 32'h1;
          2: return 32'hffff_ffff;
          3: return 32'h7fff_ffff;
          default: return 32'h8000_0000;
        endcase
      end
      default: return {{15{r[16]}}, r[16:0]};
    endcase
  endfunction

  function automatic cam_vertex_t random_vertex();
    cam_vertex_t v;
    v.x = pick_coord();
    v.y = pick_coord();
    v.z = pick_coord();
    if ($urandom_range(3) != 0) begin
      {v.active, v.clipped, v.backface} = 3'b100;
    end else begin
      {v.active, v.clipped, v.backface} = 3'($urandom_range(7));
    end
    v.last = ($urandom_range(7) == 0);
    return v;
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return 32'h0001_0000;
      3, 4: return $urandom_range(32'h0004_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_span();
    logic [12:0] s;
    logic [31:0] hi;
    hi = $urandom();
    case ($urandom_range(5))
      0: s = 13'd0;
      1: s = 13'd1;
      2: s = 13'h1fff;
      3: s = 13'd4096;
      default: s = 13'($urandom_range(4096, 1));
    endcase
    return {($urandom_range(3) == 0) ? hi[31:13] : 19'd0, s};
  endfunction

  task automatic send_vertex(cam_vertex_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cam_x <= v.x;
    cam_y <= v.y;
    cam_z <= v.z;
    poly_active <= v.active;
    poly_clipped <= v.clipped;
    poly_backface <= v.backface;
    last_in_list <= v.last;
    do @(posedge clk); while (!in_ready);
    expected_screen.push_back(project_vertex(v));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_screen.size() != 0) @(posedge clk);
  endtask

  task automatic apply_config(logic [31:0] distance, logic [31:0] asp,
                              logic [31:0] width, logic [31:0] height);
    logic [31:0] vals [4];
    vals = '{distance, asp, width, height};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= ppts_pkg::cfg_reg_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    view_dist = distance;
    aspect = asp;
    vp_w = width[12:0];
    vp_h = height[12:0];
  endtask

  task automatic test_directed_reset_config();
    view_dist = 64'h1_0000;
    aspect = 64'h1_0000;
    vp_w = 640;
    vp_h = 480;
    send_vertex(make_vertex(32'h0, 32'h0, 32'h0001_0000, 1, 0, 0, 0));
    send_vertex(make_vertex(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 1, 0, 0, 0));
    send_vertex(make_vertex(32'hffff_0000, 32'hffff_8000, 32'hffff_0000, 1, 0, 0, 1));
    // zero depth
    send_vertex(make_vertex(32'h0001_0000, 32'hfffe_0000, 32'h0, 1, 0, 0, 0));
    send_vertex(make_vertex(32'h0, 32'h0, 32'h0, 1, 0, 0, 1));
    send_vertex(make_vertex(32'h8000_0000, 32'h0, 32'h0, 1, 0, 0, 0));
    // overflow at the field extremes
    send_vertex(make_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h1, 1, 0, 0, 0));
    send_vertex(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0, 0, 0));
    send_vertex(make_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1, 0, 0, 1));
    send_vertex(make_vertex(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1, 0, 0, 0));
    // skipped polygons pass through
    send_vertex(make_vertex(32'h1234_5678, 32'h8000_0000, 32'h0001_0000, 0, 0, 0, 0));
    send_vertex(make_vertex(32'h7fff_ffff, 32'hdead_beef, 32'h0, 1, 1, 0, 1));
    send_vertex(make_vertex(32'hffff_ffff, 32'h0, 32'h0001_0000, 1, 0, 1, 0));
    send_vertex(make_vertex(32'h0, 32'hffff_ffff, 32'h8000_0000, 0, 1, 1, 1));
    drain_results();
  endtask

  task automatic test_config_extremes();
    apply_config(32'h0, 32'hffff_ffff, 32'h0, 32'h1fff);
    send_vertex(make_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1, 0, 0, 0));
    send_vertex(make_vertex(32'h0001_0000, 32'h0001_0000, 32'h0, 1, 0, 0, 0));
    send_vertex(make_vertex(32'h7fff_ffff, 32'hffff_0000, 32'h1, 1, 0, 0, 1));
    drain_results();
    apply_config(32'hffff_ffff, 32'h0, 32'h1fff, 32'h0);
    send_vertex(make_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1, 0, 0, 0));
    send_vertex(make_vertex(32'h0001_0000, 32'h0001_0000, 32'h0, 1, 0, 0, 1));
    send_vertex(make_vertex(32'hffff_0000, 32'h0000_8000, 32'h7fff_ffff, 1, 0, 0, 0));
    drain_results();
    // upper data bits above the viewport fields are dropped
    apply_config(32'hffff_ffff, 32'hffff_ffff, 32'hffff_e001, 32'h1);
    send_vertex(make_vertex(32'h1, 32'h1, 32'h7fff_ffff, 1, 0, 0, 0));
    send_vertex(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h1, 1, 0, 0, 1));
    drain_results();
  endtask

  task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    for (int blk = 0; blk < n_items / BLOCK_ITEMS; blk++) begin
      apply_config(pick_scale(), pick_scale(), pick_span(), pick_span());
      repeat (BLOCK_ITEMS) send_vertex(random_vertex());
      drain_results();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_reset_config();
    test_config_extremes();
    test_random_traffic(200, 22, 73);
    test_random_traffic(200, 73, 22);
    test_random_traffic(200, 0, 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_screen.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_screen.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected result: x=%h y=%h", screen_x, screen_y);
        end
        mismatch_count++;
      end else begin
        want_screen = expected_screen.pop_front();
        if (screen_x !== want_screen.sx || screen_y !== want_screen.sy ||
            skipped !== want_screen.skipped || zero_depth !== want_screen.zdepth ||
            saturated !== want_screen.sat || last_out !== want_screen.last) begin
          if (mismatch_count < 10) begin
            $display("mismatch: expected x=%h y=%h skip=%b zd=%b sat=%b last=%b",
                     want_screen.sx, want_screen.sy, want_screen.skipped,
                     want_screen.zdepth, want_screen.sat, want_screen.last);
            $display("          actual   x=%h y=%h skip=%b zd=%b sat=%b last=%b",
                     screen_x, screen_y, skipped, zero_depth, saturated, last_out);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
